@@ rtl/spq_pkg.sv @@
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RANK_W   = 16;
  localparam int unsigned FILL_W   = 5;
  localparam int unsigned SPAN_W   = (CNT_W > FILL_W) ? CNT_W : FILL_W;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Fill level reported when the store is full, masked to the port width
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(CAPACITY);

  typedef enum logic [1:0] {
    ST_ENQ      = 2'd0,
    ST_DEQ      = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } spq_status_e;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [RANK_W-1:0]  rank;
  } spq_entry_t;

  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t item;
  } spq_cmd_t;

endpackage

@@ rtl/spq_cell.sv @@
module spq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::spq_cmd_t cmd_i,
  input  logic              left_keep_i,
  input  logic              left_valid_i,
  input  spq_pkg::spq_entry_t left_entry_i,
  input  logic              right_valid_i,
  input  spq_pkg::spq_entry_t right_entry_i,
  output logic              valid_o,
  output spq_pkg::spq_entry_t entry_o,
  output logic              keep_o
);

  logic                valid_q, valid_d;
  spq_pkg::spq_entry_t entry_q, entry_d;

  // Entry stays put when it ranks at or before the new item
  assign keep_o = valid_q && (entry_q.rank <= cmd_i.item.rank);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (cmd_i.enq) begin
      if (keep_o) begin
        valid_d = valid_q;
        entry_d = entry_q;
      end else if (left_keep_i) begin
        valid_d = 1'b1;
        entry_d = cmd_i.item;
      end else begin
        valid_d = left_valid_i;
        entry_d = left_entry_i;
      end
    end else if (cmd_i.deq) begin
      // advance towards the head
      valid_d = right_valid_i;
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

@@ rtl/sorted_priority_queue_top.sv @@
// Sorted priority queue of spq_pkg::CAPACITY entries held in a row of cells, lowest rank at
// the head; equal ranks leave in arrival order. Each request (enqueue or dequeue) yields one
// result carrying a status, the removed entry on a successful dequeue and the fill level.
// Every cell compares against the incoming rank and shifts in the same cycle, so a new request
// is accepted every cycle while results are being taken; the single output register holds a
// result until it is taken, and a request is accepted whenever that register is empty or
// being drained. Enqueue on a full store and dequeue on an empty one leave the store as is.
module sorted_priority_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic signed [31:0] item_value_i,
  input  logic [15:0] item_rank_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic signed [31:0] out_value_o,
  output logic [15:0] out_rank_o,
  output logic [4:0]  fill_level_o
);

  localparam int unsigned N = spq_pkg::CAPACITY;

  logic                accept;
  logic                full, empty;
  spq_pkg::spq_cmd_t   cmd;
  logic                cell_valid [N];
  spq_pkg::spq_entry_t cell_entry [N];
  logic                cell_keep  [N];

  logic [spq_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [spq_pkg::SPAN_W-1:0] span;

  logic                        out_valid_q;
  spq_pkg::spq_status_e        status_q, status_d;
  spq_pkg::spq_entry_t         head_q, head_d;
  logic [spq_pkg::FILL_W-1:0]  fill_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = cell_valid[N-1];
  assign empty      = !cell_valid[0];

  always_comb begin
    cmd.item.value = item_value_i;
    cmd.item.rank  = item_rank_i;
    cmd.enq        = accept && (operation_i == spq_pkg::OP_ENQ) && !full;
    cmd.deq        = accept && (operation_i == spq_pkg::OP_DEQ) && !empty;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic                left_keep, left_valid, right_valid;
    spq_pkg::spq_entry_t left_entry, right_entry;

    if (g == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_valid = 1'b0;
      assign left_entry = '0;
    end else begin : g_mid
      assign left_keep  = cell_keep[g-1];
      assign left_valid = cell_valid[g-1];
      assign left_entry = cell_entry[g-1];
    end

    if (g == N - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_entry = '0;
    end else begin : g_body
      assign right_valid = cell_valid[g+1];
      assign right_entry = cell_entry[g+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .left_keep_i   (left_keep),
      .left_valid_i  (left_valid),
      .left_entry_i  (left_entry),
      .right_valid_i (right_valid),
      .right_entry_i (right_entry),
      .valid_o       (cell_valid[g]),
      .entry_o       (cell_entry[g]),
      .keep_o        (cell_keep[g])
    );
  end

  always_comb begin
    cnt_d    = cnt_q;
    status_d = spq_pkg::ST_ENQ;
    head_d   = '0;
    if (operation_i == spq_pkg::OP_ENQ) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        status_d = spq_pkg::ST_ENQ;
        cnt_d    = cnt_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        status_d = spq_pkg::ST_DEQ;
        head_d   = cell_entry[0];
        cnt_d    = cnt_q - 1'b1;
      end
    end
  end

  // mask the count to the port width
  assign span = spq_pkg::SPAN_W'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      head_q   <= head_d;
      fill_q   <= span[spq_pkg::FILL_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_value_o  = head_q.value;
  assign out_rank_o   = head_q.rank;
  assign fill_level_o = fill_q;

endmodule

@@ rtl/spq_checker.sv @@
module spq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] out_value_i,
  input logic [15:0] out_rank_i,
  input logic [4:0]  fill_level_i
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(out_value_i) && $stable(out_rank_i) && $stable(fill_level_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("request refused with output register empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == spq_pkg::ST_EMPTY |-> fill_level_i == '0)
    else $error("empty dequeue with nonzero fill level");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == spq_pkg::ST_FULL |-> fill_level_i == spq_pkg::FULL_FILL)
    else $error("full rejection with wrong fill level");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != spq_pkg::ST_DEQ |-> out_value_i == '0 && out_rank_i == '0)
    else $error("payload not zero outside a dequeue");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_ready_o),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_i     (status_o),
  .out_value_i  (out_value_o),
  .out_rank_i   (out_rank_o),
  .fill_level_i (fill_level_o)
);
